FILE: rtl/ptpg_pkg.sv
package ptpg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_GRID_STEP    = 3'd2,
      CSR_LINE_WIDTH   = 3'd3,
      CSR_BASE_LEVEL   = 3'd4,
      CSR_NOSE_LEVEL   = 3'd5
   } csr_index_type;

   localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd1024;
   localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd256;
   localparam logic [15:0] RST_GRID_STEP    = 16'd8704;
   localparam logic [15:0] RST_LINE_WIDTH   = 16'd8520;
   localparam logic [15:0] RST_BASE_LEVEL   = 16'd11141;
   localparam logic [15:0] RST_NOSE_LEVEL   = 16'd40632;

   localparam logic [15:0] MIN_GRID_STEP = 16'd1024;

   // low bytes of the hash multipliers; only h[7:0] is used
   localparam logic [7:0] HASH_X = 8'd93;
   localparam logic [7:0] HASH_Y = 8'd159;

endpackage

FILE: rtl/ptpg_div.sv
module ptpg_div #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo_out,
   output logic [DEN_W-1:0] rem_out
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] rem_p;
      logic [NUM_W-1:0] num_p;
      logic [NUM_W-1:0] quo_p;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_p = '0;
         assign num_p = num_in;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign num_p = num_ff[k-1];
         assign quo_p = quo_ff[k-1];
      end

      assign trial = {rem_p, num_p[NUM_W-1]};
      assign ge    = trial >= {1'b0, den};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            num_ff[k] <= num_p << 1;
            quo_ff[k] <= {quo_p[NUM_W-2:0], ge};
         end
      end
   end

   assign quo_out = quo_ff[NUM_W-1];
   assign rem_out = rem_ff[NUM_W-1];

endmodule

FILE: rtl/ptpg_dly.sv
module ptpg_dly #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             valid_in,
   input  logic [WIDTH-1:0] data_in,
   output logic             valid_out,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= data_in;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign valid_out = vld_ff[DEPTH-1];
   assign data_out  = data_ff[DEPTH-1];

endmodule

FILE: rtl/ptpg_shade.sv
module ptpg_shade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 valid_in,
   input  logic [FRAC_BITS:0]   base_lvl,
   input  logic [FRAC_BITS:0]   nose_lvl,
   input  logic [2*FRAC_BITS:0] edge_quo,
   input  logic [FRAC_BITS:0]   u_in,
   input  logic [FRAC_BITS:0]   v_in,
   input  logic [FRAC_BITS:0]   margin_in,
   input  logic [FRAC_BITS:0]   grain_in,
   output logic                 valid_out,
   output logic [7:0]           grey_out
);

   localparam int F   = FRAC_BITS;
   localparam int QW  = F + 1;
   localparam int MW  = F + 4;
   localparam int RW  = F + 8;
   localparam int N3W = F + 2;
   localparam int M3W = F + 3;
   localparam int NST = 11;

   localparam logic [MW-1:0] ONE  = MW'(64'd1 << F);
   localparam logic [MW-1:0] HALF = MW'(64'd1 << (F - 1));
   localparam logic [MW-1:0] K86 = MW'(((64'd86 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K28 = MW'(((64'd28 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K70 = MW'(((64'd70 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K80 = MW'(((64'd80 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K30 = MW'(((64'd30 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K38 = MW'(((64'd38 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K34 = MW'(((64'd34 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K42 = MW'(((64'd42 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K58 = MW'(((64'd58 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K10 = MW'(((64'd10 << F) + 64'd50) / 64'd100);
   localparam logic [MW-1:0] K14 = MW'(((64'd14 << F) + 64'd5) / 64'd10);
   localparam logic [RW-1:0] THREE_ONE = RW'(64'd3 << F);
   localparam logic [RW-1:0] ONE_R     = RW'(64'd1 << F);
   // floor(n/3) = (n*M3) >> (F+4) for n < 3*ONE
   localparam logic [M3W-1:0] M3 = M3W'(((64'd1 << (F + 4)) / 64'd3) + 64'd1);

   function automatic logic [MW-1:0] mulq(input logic [MW-1:0] a, input logic [MW-1:0] b);
      logic [2*MW-1:0] p;
      p = (2*MW)'(a) * (2*MW)'(b) + (2*MW)'(HALF);
      return MW'(p >> F);
   endfunction

   function automatic logic [MW-1:0] absdiff(input logic [MW-1:0] a, input logic [MW-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   logic [NST-1:0] vld_ff;

   // stage 0
   logic [MW-1:0] e0_ff, u0_ff, v0_ff;
   logic [QW-1:0] m0_ff, g0_ff;
   // stage 1
   logic [MW-1:0] mv1_ff, nose1_ff, t1a1_ff, t2a1_ff, wu1_ff, omv1_ff, e71_ff;
   logic [QW-1:0] m1_ff, g1_ff;
   // stage 2
   logic [MW-1:0]  bt2_ff, nsq2_ff, wsq2_ff, osq2_ff, ef2_ff;
   logic [N3W-1:0] n1_2_ff;
   logic           big2_ff;
   logic [RW-1:0]  r2_2_ff;
   logic [QW-1:0]  m2_ff, g2_ff;
   // stage 3
   logic [MW-1:0] c1_3_ff, nt3_ff, r1_3_ff, t2_3_ff, s3_ff, ef3_ff;
   logic          big3_ff;
   logic [QW-1:0] m3_ff, g3_ff;
   // stage 4
   logic [MW-1:0] c2_4_ff, t1_4_ff, t2sq4_ff, ws4_ff, nt4_ff;
   logic [QW-1:0] m4_ff, g4_ff;
   // stage 5
   logic [MW-1:0] c3_5_ff, t1sq5_ff, t2t5_ff, wear5_ff;
   logic [QW-1:0] m5_ff, g5_ff;
   // stage 6
   logic [MW-1:0] c4_6_ff, t1t6_ff, mf6_ff, wf6_ff;
   logic [QW-1:0] g6_ff;
   // stage 7
   logic [MW-1:0] c5_7_ff, mf7_ff, wf7_ff;
   logic [QW-1:0] g7_ff;
   // stage 8
   logic [MW-1:0] c6_8_ff, wf8_ff;
   logic [QW-1:0] g8_ff;
   // stage 9
   logic [MW-1:0] c7_9_ff;
   logic [QW-1:0] g9_ff;
   // stage 10
   logic [7:0]    grey_ff;

   logic [MW-1:0]   e0_in, nose1_in, nose_raw;
   logic [RW-1:0]   n1_full, p2_full;
   logic [2*F+4:0]  r1_prod;
   logic [MW:0]     c8_s, g9_s;
   logic [MW-1:0]   f_clamped;
   logic [F+8:0]    grey_sum;

   always_comb begin
      e0_in    = (edge_quo > (2*F+1)'(ONE)) ? ONE : MW'(edge_quo);
      nose_raw = (v0_ff - K80) * MW'(5);
      nose1_in = (v0_ff > K80) ? ((nose_raw > ONE) ? ONE : nose_raw) : '0;
      n1_full  = RW'(t1a1_ff) * RW'(100);
      p2_full  = RW'(t2a1_ff) * RW'(125);
      r1_prod  = (2*F+5)'(n1_2_ff) * (2*F+5)'(M3);
      g9_s     = {{(MW+1-QW){g9_ff[QW-1]}}, g9_ff};
      c8_s     = {1'b0, c7_9_ff} + g9_s;
      if (c8_s[MW]) begin
         f_clamped = '0;
      end else if (c8_s[MW-1:0] > ONE) begin
         f_clamped = ONE;
      end else begin
         f_clamped = c8_s[MW-1:0];
      end
      grey_sum = (F+9)'(f_clamped) * (F+9)'(255) + (F+9)'(HALF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff <= e0_in;
         u0_ff <= MW'(u_in);
         v0_ff <= MW'(v_in);
         m0_ff <= margin_in;
         g0_ff <= grain_in;

         mv1_ff   <= mulq(K28, v0_ff);
         nose1_ff <= nose1_in;
         t1a1_ff  <= absdiff(v0_ff, K30);
         t2a1_ff  <= absdiff(v0_ff, K38);
         wu1_ff   <= absdiff(u0_ff << 1, ONE);
         omv1_ff  <= ONE - v0_ff;
         e71_ff   <= mulq(K70, e0_ff);
         m1_ff    <= m0_ff;
         g1_ff    <= g0_ff;

         bt2_ff  <= K86 + mv1_ff;
         nsq2_ff <= mulq(nose1_ff, nose1_ff);
         n1_2_ff <= N3W'(n1_full);
         big2_ff <= n1_full >= THREE_ONE;
         r2_2_ff <= p2_full >> 1;
         wsq2_ff <= mulq(wu1_ff, wu1_ff);
         osq2_ff <= mulq(omv1_ff, omv1_ff);
         ef2_ff  <= ONE + e71_ff;
         m2_ff   <= m1_ff;
         g2_ff   <= g1_ff;

         c1_3_ff <= mulq(MW'(base_lvl), bt2_ff);
         nt3_ff  <= mulq(MW'(nose_lvl), nsq2_ff);
         r1_3_ff <= MW'(r1_prod >> (F + 4));
         big3_ff <= big2_ff;
         t2_3_ff <= (r2_2_ff >= ONE_R) ? '0 : MW'(ONE_R - r2_2_ff);
         s3_ff   <= wsq2_ff + osq2_ff;
         ef3_ff  <= ef2_ff;
         m3_ff   <= m2_ff;
         g3_ff   <= g2_ff;

         c2_4_ff  <= mulq(c1_3_ff, ef3_ff);
         t1_4_ff  <= big3_ff ? '0 : ONE - r1_3_ff;
         t2sq4_ff <= mulq(t2_3_ff, t2_3_ff);
         ws4_ff   <= mulq(s3_ff, K14);
         nt4_ff   <= nt3_ff;
         m4_ff    <= m3_ff;
         g4_ff    <= g3_ff;

         c3_5_ff  <= c2_4_ff + nt4_ff;
         t1sq5_ff <= mulq(t1_4_ff, t1_4_ff);
         t2t5_ff  <= mulq(K34, t2sq4_ff);
         wear5_ff <= (ws4_ff >= ONE) ? '0 : ONE - ws4_ff;
         m5_ff    <= m4_ff;
         g5_ff    <= g4_ff;

         c4_6_ff <= c3_5_ff + t2t5_ff;
         t1t6_ff <= mulq(K34, t1sq5_ff);
         mf6_ff  <= K42 + mulq(K58, MW'(m5_ff));
         wf6_ff  <= ONE + mulq(K10, wear5_ff);
         g6_ff   <= g5_ff;

         c5_7_ff <= c4_6_ff + t1t6_ff;
         mf7_ff  <= mf6_ff;
         wf7_ff  <= wf6_ff;
         g7_ff   <= g6_ff;

         c6_8_ff <= mulq(c5_7_ff, mf7_ff);
         wf8_ff  <= wf7_ff;
         g8_ff   <= g7_ff;

         c7_9_ff <= mulq(c6_8_ff, wf8_ff);
         g9_ff   <= g8_ff;

         grey_ff <= 8'(grey_sum >> F);
      end
   end

   assign valid_out = vld_ff[NST-1];
   assign grey_out  = grey_ff;

endmodule

FILE: rtl/panel_texture_pixel_generator_top.sv
// Pipeline: input register, the bit-per-stage coordinate/phase dividers, lattice distance
// register, the bit-per-stage lattice edge divider, then the shading stages.
// Throughput: one request per clock; the whole pipeline stalls while a result is held.
// Reset: synchronous, active high; clears all valid bits and loads register defaults.
// No request is taken while reset is high.
module panel_texture_pixel_generator_top
   import ptpg_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [COORD_BITS-1:0] pixel_x, [2*COORD_BITS-1:COORD_BITS] pixel_y
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] grey_value
   output logic [7:0]                            rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_INDEX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]                 csr_data
);

   localparam int C       = COORD_BITS;
   localparam int F       = FRAC_BITS;
   localparam int QW      = F + 1;
   localparam int EXT_W   = 17;
   localparam int DIV_NW  = C + F + 9;
   localparam int DIV_DW  = 16;
   localparam int EDGE_NW = 2*F + 1;
   localparam int EDGE_DW = QW;
   localparam int D1_W    = 2*QW + 1;
   localparam int D2_W    = 4*QW;

   localparam logic [QW-1:0]  ONE_Q  = QW'(64'd1 << F);
   localparam logic [QW-1:0]  HALF_Q = QW'(64'd1 << (F - 1));
   localparam logic [F-1:0]   HALF_F = F'(64'd1 << (F - 1));
   localparam logic [QW-1:0]  K45    = QW'(((64'd45 << F) + 64'd50) / 64'd100);
   localparam logic [EXT_W-1:0] MARGIN_PX = EXT_W'(18);

   typedef logic [QW-1:0] grain_tab_type  [256];
   typedef logic [QW-1:0] margin_tab_type [32];

   function automatic grain_tab_type grain_tab_init();
      grain_tab_type tab;
      longint g;
      longint gm;
      for (int i = 0; i < 256; i++) begin
         g  = 2 * i - 255;
         gm = (((g < 0) ? -g : g) << F) + 12750;
         gm = gm / 25500;
         tab[i] = (g < 0) ? QW'(-gm) : QW'(gm);
      end
      return tab;
   endfunction

   function automatic margin_tab_type margin_tab_init();
      margin_tab_type tab;
      for (int i = 0; i < 32; i++) begin
         tab[i] = (i < 18) ? QW'((longint'(i) << F) / 18) : ONE_Q;
      end
      return tab;
   endfunction

   localparam grain_tab_type  GRAIN_TAB  = grain_tab_init();
   localparam margin_tab_type MARGIN_TAB = margin_tab_init();

   function automatic logic [QW-1:0] from16(input logic [15:0] v);
      logic [F+16:0] t;
      t = ((F+17)'(v) << F) + (F+17)'(32768);
      return QW'(t >> 16);
   endfunction

   function automatic logic [QW-1:0] pdist(input logic [F-1:0] fr);
      logic [F-1:0] a;
      a = fr[F-1] ? fr - HALF_F : HALF_F - fr;
      return {a, 1'b0};
   endfunction

   // ---------------- registers ----------------
   logic [12:0] width_ff, height_ff;
   logic [15:0] step_ff, linew_ff, base_ff, nose_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         step_ff   <= RST_GRID_STEP;
         linew_ff  <= RST_LINE_WIDTH;
         base_ff   <= RST_BASE_LEVEL;
         nose_ff   <= RST_NOSE_LEVEL;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[12:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[12:0];
            CSR_GRID_STEP:    step_ff   <= csr_data;
            CSR_LINE_WIDTH:   linew_ff  <= csr_data;
            CSR_BASE_LEVEL:   base_ff   <= csr_data;
            CSR_NOSE_LEVEL:   nose_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = !reset;

   // derived settings
   logic [12:0]    dw_ff, dh_ff;
   logic [15:0]    pitch_ff;
   logic [QW-1:0]  lw_ff, base_q_ff, nose_q_ff, den_ff, den_raw;
   logic [2*QW-1:0] den_prod;

   always_comb begin
      den_prod = (2*QW)'(lw_ff) * (2*QW)'(K45) + (2*QW)'(HALF_Q);
      den_raw  = QW'(den_prod >> F);
   end

   always_ff @(posedge clock) begin
      dw_ff     <= (width_ff > 13'd1) ? width_ff - 13'd1 : 13'd1;
      dh_ff     <= (height_ff > 13'd1) ? height_ff - 13'd1 : 13'd1;
      pitch_ff  <= (step_ff < MIN_GRID_STEP) ? MIN_GRID_STEP : step_ff;
      lw_ff     <= from16(linew_ff);
      base_q_ff <= from16(base_ff);
      nose_q_ff <= from16(nose_ff);
      den_ff    <= (den_raw == '0) ? QW'(1) : den_raw;
   end

   // ---------------- input stage ----------------
   logic         en;
   logic         v0_ff;
   logic [C-1:0] x_ff, y_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= req_tdata[C-1:0];
         y_ff <= req_tdata[2*C-1:C];
      end
   end

   logic [EXT_W-1:0]  x_w, y_w, bx_w, dmx_w;
   logic [C-1:0]      xc, yc, diff;
   logic [C:0]        sum;
   logic              neg;
   logic [12:0]       dmx;
   logic [7:0]        h8;
   logic [QW-1:0]     margin0, grain0;
   logic [DIV_NW-1:0] u_num, v_num, s_num, d_num;

   always_comb begin
      x_w   = EXT_W'(x_ff);
      y_w   = EXT_W'(y_ff);
      xc    = (x_w < EXT_W'(dw_ff)) ? x_ff : C'(dw_ff);
      yc    = (y_w < EXT_W'(dh_ff)) ? y_ff : C'(dh_ff);
      u_num = (DIV_NW'(xc) << F) + DIV_NW'(dw_ff >> 1);
      v_num = (DIV_NW'(yc) << F) + DIV_NW'(dh_ff >> 1);
      sum   = (C+1)'(x_ff) + (C+1)'(y_ff);
      neg   = x_ff < y_ff;
      diff  = neg ? y_ff - x_ff : x_ff - y_ff;
      s_num = DIV_NW'(sum) << (F + 8);
      d_num = DIV_NW'(diff) << (F + 8);
      dmx   = dw_ff - 13'(xc);
      dmx_w = EXT_W'(dmx);
      bx_w  = (EXT_W'(xc) < dmx_w) ? EXT_W'(xc) : dmx_w;
      margin0 = (bx_w >= MARGIN_PX) ? ONE_Q : MARGIN_TAB[bx_w[4:0]];
      h8      = 8'(x_w[7:0] * HASH_X) ^ 8'(y_w[7:0] * HASH_Y);
      grain0  = GRAIN_TAB[h8];
   end

   // ---------------- coordinate and phase dividers ----------------
   logic [DIV_NW-1:0] u_quo, v_quo, s_quo, d_quo;
   logic [DIV_DW-1:0] u_rem, v_rem, s_rem, d_rem;

   ptpg_div #(.NUM_W(DIV_NW), .DEN_W(DIV_DW)) u_div_u (
      .clock(clock), .en(en), .num_in(u_num), .den(DIV_DW'(dw_ff)),
      .quo_out(u_quo), .rem_out(u_rem)
   );

   ptpg_div #(.NUM_W(DIV_NW), .DEN_W(DIV_DW)) u_div_v (
      .clock(clock), .en(en), .num_in(v_num), .den(DIV_DW'(dh_ff)),
      .quo_out(v_quo), .rem_out(v_rem)
   );

   ptpg_div #(.NUM_W(DIV_NW), .DEN_W(DIV_DW)) u_div_sum (
      .clock(clock), .en(en), .num_in(s_num), .den(pitch_ff),
      .quo_out(s_quo), .rem_out(s_rem)
   );

   ptpg_div #(.NUM_W(DIV_NW), .DEN_W(DIV_DW)) u_div_diff (
      .clock(clock), .en(en), .num_in(d_num), .den(pitch_ff),
      .quo_out(d_quo), .rem_out(d_rem)
   );

   logic            d1_valid;
   logic [D1_W-1:0] d1_data;

   ptpg_dly #(.WIDTH(D1_W), .DEPTH(DIV_NW)) u_dly_div (
      .clock(clock), .reset(reset), .en(en), .valid_in(v0_ff),
      .data_in({neg, grain0, margin0}),
      .valid_out(d1_valid), .data_out(d1_data)
   );

   // ---------------- lattice distance stage ----------------
   logic [F-1:0]  fr_s, fr_d, t_low;
   logic [QW-1:0] dist_s, dist_d;

   always_comb begin
      fr_s   = s_quo[F-1:0];
      t_low  = d_quo[F-1:0] + F'(d_rem != '0);
      fr_d   = d1_data[D1_W-1] ? F'(0) - t_low : d_quo[F-1:0];
      dist_s = pdist(fr_s);
      dist_d = pdist(fr_d);
   end

   logic          vp_ff;
   logic [QW-1:0] d_ff, u_ff, v_ff, marg_ff, grain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (en) begin
         vp_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= (dist_d < dist_s) ? dist_d : dist_s;
         u_ff     <= u_quo[F:0];
         v_ff     <= v_quo[F:0];
         marg_ff  <= d1_data[QW-1:0];
         grain_ff <= d1_data[2*QW-1:QW];
      end
   end

   // ---------------- lattice edge divider ----------------
   logic [EDGE_NW-1:0] e_num, e_quo;
   logic [EDGE_DW-1:0] e_rem;

   assign e_num = (lw_ff > d_ff) ? (EDGE_NW'(lw_ff - d_ff) << F) : '0;

   ptpg_div #(.NUM_W(EDGE_NW), .DEN_W(EDGE_DW)) u_div_edge (
      .clock(clock), .en(en), .num_in(e_num), .den(den_ff),
      .quo_out(e_quo), .rem_out(e_rem)
   );

   logic            d2_valid;
   logic [D2_W-1:0] d2_data;

   ptpg_dly #(.WIDTH(D2_W), .DEPTH(EDGE_NW)) u_dly_edge (
      .clock(clock), .reset(reset), .en(en), .valid_in(vp_ff),
      .data_in({grain_ff, marg_ff, v_ff, u_ff}),
      .valid_out(d2_valid), .data_out(d2_data)
   );

   // ---------------- shading ----------------
   ptpg_shade #(.FRAC_BITS(F)) u_shade (
      .clock(clock),
      .reset(reset),
      .en(en),
      .valid_in(d2_valid),
      .base_lvl(base_q_ff),
      .nose_lvl(nose_q_ff),
      .edge_quo(e_quo),
      .u_in(d2_data[QW-1:0]),
      .v_in(d2_data[2*QW-1:QW]),
      .margin_in(d2_data[3*QW-1:2*QW]),
      .grain_in(d2_data[4*QW-1:3*QW]),
      .valid_out(rsp_tvalid),
      .grey_out(rsp_tdata)
   );

endmodule

FILE: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ptpg_pkg::*;

   localparam longint ONE       = 64'sd1 << 16;
   localparam longint HALF      = 64'sd1 << 15;
   localparam int     MAX_WAIT  = 14;
   localparam int     SETTLE    = 120;
   localparam longint CYCLE_CAP = 3000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   longint unsigned img_w, img_h, pitch, line_w, base_lvl, nose_lvl;
   logic [7:0] grey_queue[$];
   int     mismatches;
   int     grey_count;
   int     request_count;
   longint cycle_count;
   bit     req_quiet;
   bit     rsp_quiet;

   panel_texture_pixel_generator_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint mag(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic longint clamp01(longint a);
      return a < 0 ? 64'sd0 : (a > ONE ? ONE : a);
   endfunction

   function automatic longint frac_of(longint n, longint d);
      return ((n <<< 16) + d / 2) / d;
   endfunction

   function automatic longint fmul(longint a, longint b);
      longint unsigned m;
      m = (longint'(mag(a)) * longint'(mag(b)) + HALF);
      m = m >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint q16(longint unsigned r);
      return longint'((((r & 64'hFFFF) << 16) + 64'd32768) >> 16);
   endfunction

   function automatic longint lattice_dist(longint diff, longint unsigned stp);
      longint unsigned t;
      longint unsigned n;
      longint unsigned fr;
      longint unsigned msk;
      msk = ONE - 1;
      if (diff >= 0) begin
         t = (longint'(diff) << 24) / stp;
         fr = t & msk;
      end else begin
         n = longint'(-diff) << 24;
         t = (n + stp - 1) / stp;
         fr = (longint'(ONE) - (t & msk)) & msk;
      end
      return mag(longint'(fr) - HALF) * 2;
   endfunction

   function automatic longint stripe_gain(longint v, longint at, longint num, longint den);
      return clamp01(ONE - mag(v - at) * num / den);
   endfunction

   function automatic logic [7:0] grey_of(longint x, longint y);
      longint dw, dh, xc, yc, u, v, lw, c, d, db, den, edge_w, nose, t, bx, margin;
      longint wu, s, wear, g, gm, f;
      longint unsigned stp;
      bit [31:0] hx, hy, h;
      dw = img_w > 1 ? longint'(img_w) - 1 : 1;
      dh = img_h > 1 ? longint'(img_h) - 1 : 1;
      xc = x < dw ? x : dw;
      yc = y < dh ? y : dh;
      u = ((xc <<< 16) + dw / 2) / dw;
      v = ((yc <<< 16) + dh / 2) / dh;
      stp = pitch < 1024 ? 1024 : pitch;
      lw = q16(line_w);
      c = fmul(q16(base_lvl), frac_of(86, 100) + fmul(frac_of(28, 100), v));
      d = lattice_dist(x + y, stp);
      db = lattice_dist(x - y, stp);
      if (db < d) d = db;
      den = fmul(lw, frac_of(45, 100));
      if (den < 1) den = 1;
      edge_w = lw > d ? ((lw - d) <<< 16) / den : 0;
      edge_w = clamp01(edge_w);
      c = fmul(c, ONE + fmul(frac_of(70, 100), edge_w));
      nose = v > frac_of(80, 100) ? clamp01((v - frac_of(80, 100)) * 5) : 0;
      c += fmul(q16(nose_lvl), fmul(nose, nose));
      t = stripe_gain(v, frac_of(30, 100), 100, 3);
      c += fmul(frac_of(34, 100), fmul(t, t));
      t = stripe_gain(v, frac_of(38, 100), 125, 2);
      c += fmul(frac_of(34, 100), fmul(t, t));
      bx = (xc < dw - xc) ? xc : dw - xc;
      margin = clamp01((bx <<< 16) / 18);
      c = fmul(c, frac_of(42, 100) + fmul(frac_of(58, 100), margin));
      wu = 2 * u - ONE;
      s = fmul(wu, wu) + fmul(ONE - v, ONE - v);
      wear = clamp01(ONE - fmul(s, frac_of(14, 10)));
      c = fmul(c, ONE + fmul(frac_of(10, 100), wear));
      hx = x[31:0];
      hy = y[31:0];
      h = (hx * 32'd73856093) ^ (hy * 32'd19349663);
      g = 2 * longint'(h[7:0]) - 255;
      gm = ((mag(g) <<< 16) + 12750) / 25500;
      c += g < 0 ? -gm : gm;
      f = clamp01(c);
      return 8'((f * 255 + HALF) >>> 16);
   endfunction

   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // request driver; valid stays high across back-to-back requests
   task automatic send_pixel(logic [11:0] x, logic [11:0] y);
      int gap;
      gap = draw_gap(req_quiet);
      if ($urandom_range(0, 60) == 0) req_quiet = ~req_quiet;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      grey_queue.push_back(grey_of(longint'(x), longint'(y)));
      request_count++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (grey_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  img_w    = value & 16'h1FFF;
         CSR_IMAGE_HEIGHT: img_h    = value & 16'h1FFF;
         CSR_GRID_STEP:    pitch    = value;
         CSR_LINE_WIDTH:   line_w   = value;
         CSR_BASE_LEVEL:   base_lvl = value;
         CSR_NOSE_LEVEL:   nose_lvl = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(logic [15:0] w, logic [15:0] h, logic [15:0] stp,
                                logic [15:0] lw, logic [15:0] bl, logic [15:0] nl);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_GRID_STEP, stp);
      write_reg(CSR_LINE_WIDTH, lw);
      write_reg(CSR_BASE_LEVEL, bl);
      write_reg(CSR_NOSE_LEVEL, nl);
   endtask

   task automatic test_default_corners();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1023, 12'd255);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd511, 12'd128);
      send_pixel(12'd512, 12'd240);
      send_pixel(12'd17, 12'd77);
      send_pixel(12'd2000, 12'd10);
      send_pixel(12'd5, 12'd3000);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
   endtask

   task automatic test_extreme_settings();
      load_settings(16'd8, 16'd8, 16'd1024, 16'd65535, 16'd65535, 16'd65535);
      send_pixel(12'd0, 12'd7);
      send_pixel(12'd7, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd3, 12'd6);
      load_settings(16'd4096, 16'd4096, 16'd65535, 16'd0, 16'd0, 16'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd2048, 12'd3500);
      // degenerate size, pitch below minimum
      load_settings(16'd1, 16'd0, 16'd5, 16'd1, 16'd40000, 16'd30000);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd9, 12'd4);
      send_pixel(12'd4095, 12'd1);
      load_settings(16'd8191, 16'd2, 16'd0, 16'd30000, 16'd20000, 16'd65535);
      send_pixel(12'd100, 12'd1);
      send_pixel(12'd4095, 12'd0);
   endtask

   task automatic test_random_pixels(int count);
      logic [11:0] x, y;
      int w, h;
      for (int i = 0; i < count; i++) begin
         if (i % 250 == 0) begin
            w = $urandom_range(0, 3) == 0 ? 8 : $urandom_range(8, 4096);
            h = $urandom_range(0, 3) == 0 ? 4096 : $urandom_range(8, 4096);
            load_settings(16'(w), 16'(h), 16'($urandom_range(1024, 65535)),
                          16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)));
         end
         if ($urandom_range(0, 7) == 0) begin
            x = 12'($urandom);
            y = 12'($urandom);
         end else begin
            x = 12'($urandom_range(0, w - 1));
            y = 12'($urandom_range(0, h - 1));
         end
         send_pixel(x, y);
      end
   endtask

   initial begin
      int gap;
      forever begin
         gap = draw_gap(rsp_quiet);
         if ($urandom_range(0, 60) == 0) rsp_quiet = ~rsp_quiet;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         grey_count++;
         if (grey_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected grey value %0d", rsp_tdata);
         end else begin
            want = grey_queue.pop_front();
            if (want !== rsp_tdata) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("grey_value mismatch: expected %0d actual %0d", want, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** panel_texture_pixel_generator_top: FAILED **");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_data = '0;
      mismatches = 0;
      grey_count = 0;
      request_count = 0;
      cycle_count = 0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      img_w = RST_IMAGE_WIDTH;
      img_h = RST_IMAGE_HEIGHT;
      pitch = RST_GRID_STEP;
      line_w = RST_LINE_WIDTH;
      base_lvl = RST_BASE_LEVEL;
      nose_lvl = RST_NOSE_LEVEL;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_corners();
      test_extreme_settings();
      test_random_pixels(1750);
      wait_idle();
      $display("%0d pixel requests, %0d grey values checked, %0d mismatches",
               request_count, grey_count, mismatches);
      $display("covered reset defaults, extreme and degenerate settings, random settings");
      if (mismatches == 0 && grey_queue.size() == 0)
         $display("** panel_texture_pixel_generator_top: PASSED **");
      else
         $display("** panel_texture_pixel_generator_top: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ptpg_pkg.sv
rtl/ptpg_div.sv
rtl/ptpg_dly.sv
rtl/ptpg_shade.sv
rtl/panel_texture_pixel_generator_top.sv
dv/tb_top.sv
